// ===== hw/rtl/pvm_pkg.sv =====
// Shared types, codes and constants of the piano voice manager.
package pvm_pkg;

  localparam int VOICES = 32;
  localparam int SLOT_W = $clog2(VOICES);

  localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
  localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
  localparam logic [2:0] MODE_SUSTAIN  = 3'd2;
  localparam logic [2:0] MODE_SOST     = 3'd3;
  localparam logic [2:0] MODE_SOFT     = 3'd4;
  localparam logic [2:0] MODE_LEVEL    = 3'd5;
  localparam logic [2:0] MODE_ALL_OFF  = 3'd6;
  localparam logic [2:0] MODE_RSVD     = 3'd7;

  localparam logic [2:0] CFG_CONT_PEDAL = 3'd0;
  localparam logic [2:0] CFG_UNA_CORDA  = 3'd1;
  localparam logic [2:0] CFG_DUP_WINDOW = 3'd2;
  localparam logic [2:0] CFG_RET_AGE    = 3'd3;
  localparam logic [2:0] CFG_RET_LEVEL  = 3'd4;

  localparam int FL_HELD = 0;
  localparam int FL_SUST = 1;
  localparam int FL_SOST = 2;
  localparam int FL_FADE = 3;

  localparam logic [31:0] LEVEL_ONE = 32'h0100_0000;
  localparam logic [32:0] PRIO_HELD = 33'd167772160;
  localparam logic [32:0] PRIO_PED  = 33'd16777216;
  localparam logic [6:0]  DAMP_FULL = 7'd127;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_FADE    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_DAMPER  = 3'd3,
    ACT_FREED   = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    OP_NOTE_ON, OP_NOTE_OFF, OP_SUSTAIN, OP_SOST, OP_SOFT, OP_LEVEL, OP_ALL_OFF, OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  note;
    logic [6:0]  value;
    logic [4:0]  voice_index;
    logic [31:0] level;
    logic        faded;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    act_t        action;
    logic [4:0]  voice_slot;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [6:0]  damper_amount;
    logic [6:0]  soft_amount;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    op_t       op;
    in_word_t  word;
  } cmd_t;

  typedef struct packed {
    logic        continuous_pedal;
    logic        una_corda_enable;
    logic [15:0] duplicate_window;
    logic [19:0] retire_age;
    logic [24:0] retire_level;
  } cfg_t;

endpackage

// ===== hw/rtl/piano_voice_manager_top.sv =====
// Top level of the piano voice manager: config registers, front queue, engine, result queue.
//
// Events enter a two-word queue; the engine takes one event at a time and walks the
// 32-slot voice table one slot per cycle while the result queue has room. A note-on makes
// one pass for the duplicate check and slot choice, one pass issuing fades, then the start;
// note-off, sustain, sostenuto and all-off make one pass, a level report reads one slot.
// A full result queue holds the engine. The last word of an event carries last.
module piano_voice_manager_top (
  input  logic               clk,
  input  logic               rst,
  input  pvm_pkg::in_word_t  in_word,
  input  logic               push,
  output logic               full,
  output pvm_pkg::out_word_t out_word,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);
  import pvm_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd;
  logic      cmd_pop;
  out_word_t oq_word;
  logic      oq_push;
  logic      oq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.continuous_pedal <= 1'b1;
      cfg.una_corda_enable <= 1'b1;
      cfg.duplicate_window <= 16'd240;
      cfg.retire_age       <= 20'd24000;
      cfg.retire_level     <= 25'd503;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONT_PEDAL: cfg.continuous_pedal <= cfg_data[0];
        CFG_UNA_CORDA:  cfg.una_corda_enable <= cfg_data[0];
        CFG_DUP_WINDOW: cfg.duplicate_window <= cfg_data[15:0];
        CFG_RET_AGE:    cfg.retire_age       <= cfg_data[19:0];
        CFG_RET_LEVEL:  cfg.retire_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  pvm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  pvm_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .cmd_pop (cmd_pop),
    .oq_word (oq_word),
    .oq_push (oq_push),
    .oq_full (oq_full)
  );

  pvm_out_q u_out_q (
    .clk      (clk),
    .rst      (rst),
    .wr_word  (oq_word),
    .wr_en    (oq_push),
    .wr_full  (oq_full),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> !oq_full)
    else $error("result word pushed into full queue");

  a_accept_visible: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> cmd.valid)
    else $error("accepted event word not visible to engine");

  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd.valid)
    else $error("engine took an event from an empty queue");
`endif

endmodule

// ===== hw/rtl/pvm_front.sv =====
// Input queue of event words with mode decode at its head.
module pvm_front (
  input  logic              clk,
  input  logic              rst,
  input  pvm_pkg::in_word_t in_word,
  input  logic              push,
  output logic              full,
  output pvm_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);
  import pvm_pkg::*;

  in_word_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && cmd.valid;

  always_comb begin
    cmd.valid = (count != 2'd0);
    cmd.word  = mem[rd_ptr];
    unique case (mem[rd_ptr].mode)
      MODE_NOTE_ON:  cmd.op = OP_NOTE_ON;
      MODE_NOTE_OFF: cmd.op = OP_NOTE_OFF;
      MODE_SUSTAIN:  cmd.op = OP_SUSTAIN;
      MODE_SOST:     cmd.op = OP_SOST;
      MODE_SOFT:     cmd.op = OP_SOFT;
      MODE_LEVEL:    cmd.op = OP_LEVEL;
      MODE_ALL_OFF:  cmd.op = OP_ALL_OFF;
      default:       cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (!do_push && do_pop) count <= count - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/pvm_out_q.sv =====
// Result queue between the voice engine and the result ports.
module pvm_out_q (
  input  logic               clk,
  input  logic               rst,
  input  pvm_pkg::out_word_t wr_word,
  input  logic               wr_en,
  output logic               wr_full,
  output pvm_pkg::out_word_t out_word,
  output logic               empty,
  input  logic               pop
);
  import pvm_pkg::*;

  out_word_t  mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign wr_full  = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign out_word = mem[rd_ptr];
  assign do_push  = wr_en && !wr_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      if (do_push && !do_pop) count <= count + 3'd1;
      else if (!do_push && do_pop) count <= count - 3'd1;
    end
  end

endmodule

// ===== hw/rtl/pvm_engine.sv =====
// Voice table and sequencer that scans the slots and issues voice commands.
module pvm_engine (
  input  logic               clk,
  input  logic               rst,
  input  pvm_pkg::cfg_t      cfg,
  input  pvm_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output pvm_pkg::out_word_t oq_word,
  output logic               oq_push,
  input  logic               oq_full
);
  import pvm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_FADE, ST_START, ST_LVL, ST_FLUSH
  } state_t;

  state_t              state;
  op_t                 op;
  in_word_t            item;
  logic [SLOT_W-1:0]   idx;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [32:0]         best;
  logic [SLOT_W-1:0]   best_idx;
  logic                rel_mode;
  logic [6:0]          sus_pos;
  logic                sus_down;
  logic [6:0]          soft_pos;
  logic                sost_down;
  out_word_t           pend;
  logic                pend_valid;

  logic                used [VOICES];
  logic [3:0]          flags [VOICES];
  logic [6:0]          key_mem [VOICES];
  logic [31:0]         lvl_mem [VOICES];
  logic [31:0]         st_mem [VOICES];

  logic [SLOT_W-1:0]   rd_idx;
  logic [SLOT_W-1:0]   new_slot;
  logic                u;
  logic [3:0]          f;
  logic [6:0]          k;
  logic                match;
  logic [31:0]         age;
  logic [32:0]         prio;
  logic                last_idx;
  logic                emit_req;
  out_word_t           ew;
  logic                can_emit;
  logic                adv;
  logic                retire;

  always_comb begin
    rd_idx   = (state == ST_LVL) ? item.voice_index : idx;
    new_slot = free_found ? free_idx : best_idx;
    u        = used[rd_idx];
    f        = flags[rd_idx];
    k        = key_mem[rd_idx];
    match    = u && (k == item.note) && !f[FL_FADE];
    age      = item.now - st_mem[rd_idx];
    prio     = {1'b0, lvl_mem[rd_idx]} + (f[FL_HELD] ? PRIO_HELD : 33'd0)
             + ((f[FL_SUST] || f[FL_SOST]) ? PRIO_PED : 33'd0);
    last_idx = (idx == SLOT_W'(VOICES - 1));
    retire   = ((item.level < 32'(cfg.retire_level)) && (age > 32'(cfg.retire_age)))
             || (f[FL_FADE] && item.faded);
    emit_req = 1'b0;
    ew       = '0;
    ew.voice_slot = rd_idx;
    ew.key        = k;
    unique case (state)
      ST_SCAN: begin
        case (op)
          OP_NOTE_OFF: begin
            if (u && k == item.note && f[FL_HELD] && !f[FL_FADE] &&
                (cfg.continuous_pedal || !(sus_down || f[FL_SOST]))) begin
              emit_req  = 1'b1;
              ew.action = ACT_RELEASE;
            end
          end
          OP_SUSTAIN: begin
            if (cfg.continuous_pedal && u) begin
              emit_req         = 1'b1;
              ew.action        = ACT_DAMPER;
              ew.damper_amount = f[FL_SOST] ? DAMP_FULL : sus_pos;
            end else if (rel_mode && u && f[FL_SUST] && !f[FL_HELD] && !f[FL_SOST]) begin
              emit_req  = 1'b1;
              ew.action = ACT_RELEASE;
            end
          end
          OP_SOST: begin
            if (!sost_down && u && f[FL_SOST]) begin
              if (cfg.continuous_pedal) begin
                emit_req         = 1'b1;
                ew.action        = ACT_DAMPER;
                ew.damper_amount = sus_pos;
              end else if (!f[FL_HELD] && !sus_down) begin
                emit_req  = 1'b1;
                ew.action = ACT_RELEASE;
              end
            end
          end
          OP_ALL_OFF: begin
            if (u) begin
              emit_req  = 1'b1;
              ew.action = ACT_FREED;
            end
          end
          default: ;
        endcase
      end
      ST_FADE: begin
        if (match) begin
          emit_req  = 1'b1;
          ew.action = ACT_FADE;
        end
      end
      ST_START: begin
        emit_req         = 1'b1;
        ew.action        = ACT_START;
        ew.voice_slot    = new_slot;
        ew.key           = item.note;
        ew.velocity      = item.value;
        ew.damper_amount = cfg.continuous_pedal ? sus_pos : 7'd0;
        ew.soft_amount   = (cfg.continuous_pedal && cfg.una_corda_enable) ? soft_pos : 7'd0;
      end
      ST_LVL: begin
        if (u && retire && (32'(item.voice_index) < VOICES)) begin
          emit_req  = 1'b1;
          ew.action = ACT_FREED;
        end
      end
      default: ;
    endcase
    can_emit = !pend_valid || !oq_full;
    adv      = !emit_req || can_emit;
    cmd_pop  = (state == ST_IDLE) && cmd.valid;
    oq_word  = pend;
    oq_push  = 1'b0;
    if (state == ST_FLUSH) begin
      oq_word.last = 1'b1;
      oq_push      = pend_valid && !oq_full;
    end else begin
      oq_word.last = 1'b0;
      oq_push      = emit_req && can_emit && pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_START && adv) begin
      key_mem[new_slot] <= item.note;
      lvl_mem[new_slot] <= LEVEL_ONE;
      st_mem[new_slot]  <= item.now;
    end else if (state == ST_LVL && u && (32'(item.voice_index) < VOICES)) begin
      lvl_mem[rd_idx] <= item.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      sus_pos    <= 7'd0;
      sus_down   <= 1'b0;
      soft_pos   <= 7'd0;
      sost_down  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        used[i]  <= 1'b0;
        flags[i] <= 4'd0;
      end
    end else begin
      if (emit_req && can_emit) begin
        pend       <= ew;
        pend_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            item       <= cmd.word;
            op         <= cmd.op;
            idx        <= '0;
            free_found <= 1'b0;
            best       <= '1;
            best_idx   <= '0;
            unique case (cmd.op)
              OP_NOTE_ON, OP_NOTE_OFF, OP_ALL_OFF: state <= ST_SCAN;
              OP_SUSTAIN: begin
                sus_pos  <= cmd.word.value;
                rel_mode <= !cfg.continuous_pedal && sus_down && !cmd.word.value[6];
                sus_down <= cmd.word.value[6];
                state    <= ST_SCAN;
              end
              OP_SOST: begin
                sost_down <= cmd.word.value[6];
                state     <= ST_SCAN;
              end
              OP_SOFT:  soft_pos <= cmd.word.value;
              OP_LEVEL: state <= ST_LVL;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (adv) begin
            case (op)
              OP_NOTE_OFF: begin
                if (u && k == item.note && f[FL_HELD] && !f[FL_FADE]) begin
                  flags[rd_idx][FL_HELD] <= 1'b0;
                  if (!cfg.continuous_pedal) begin
                    flags[rd_idx][FL_SUST] <= sus_down || f[FL_SOST];
                  end
                end
              end
              OP_SUSTAIN: begin
                if (rel_mode && u && f[FL_SUST] && !f[FL_HELD] && !f[FL_SOST]) begin
                  flags[rd_idx][FL_SUST] <= 1'b0;
                end
              end
              OP_SOST: begin
                if (sost_down) begin
                  if (u && f[FL_HELD]) flags[rd_idx][FL_SOST] <= 1'b1;
                end else if (u && f[FL_SOST]) begin
                  flags[rd_idx][FL_SOST] <= 1'b0;
                  if (!cfg.continuous_pedal && !f[FL_HELD] && !sus_down) begin
                    flags[rd_idx][FL_SUST] <= 1'b0;
                  end
                end
              end
              OP_ALL_OFF: used[rd_idx] <= 1'b0;
              default: ;
            endcase
            if (op == OP_NOTE_ON) begin
              if (!u && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= idx;
              end
              if (u && prio < best) begin
                best     <= prio;
                best_idx <= idx;
              end
            end
            if (op == OP_NOTE_ON && match && (age < 32'(cfg.duplicate_window))) begin
              state <= ST_FLUSH;
            end else if (last_idx) begin
              idx   <= '0;
              state <= (op == OP_NOTE_ON) ? ST_FADE : ST_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FADE: begin
          if (adv) begin
            if (match) flags[rd_idx][FL_FADE] <= 1'b1;
            if (last_idx) state <= ST_START;
            else idx <= idx + 1'b1;
          end
        end
        ST_START: begin
          if (adv) begin
            used[new_slot]  <= 1'b1;
            flags[new_slot] <= 4'(1 << FL_HELD);
            state           <= ST_FLUSH;
          end
        end
        ST_LVL: begin
          if (adv) begin
            if (emit_req) used[rd_idx] <= 1'b0;
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (!oq_full) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
